FILE: rtl/u8sd_pkg.sv
package u8sd_pkg;

  localparam int unsigned POS_W = 17;
  localparam int unsigned CP_W = 31;
  localparam int unsigned LEN_W = 3;

  // saturation limit for positions and counts: smaller of the string limit and 1FFFF
  localparam longint unsigned MAX_BYTES = 64'd65536;
  localparam longint unsigned POS_MAX = 64'h1FFFF;
  localparam logic [POS_W-1:0] SAT_CAP =
    (MAX_BYTES < POS_MAX) ? POS_W'(MAX_BYTES) : POS_W'(POS_MAX);

  localparam logic [CP_W-1:0] SURR_LO = 31'h0000D800;
  localparam logic [CP_W-1:0] SURR_HI = 31'h0000DFFF;
  localparam logic [CP_W-1:0] STRICT_MAX = 31'h0010FFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } u8sd_in_t;

  typedef struct packed {
    logic [CP_W-1:0]  codepoint;
    logic [POS_W-1:0] start_position;
    logic [LEN_W-1:0] byte_length;
    logic             codepoint_valid;
    logic             error;
    logic [POS_W-1:0] char_count;
    logic             end_of_string;
  } u8sd_out_t;

endpackage

FILE: rtl/utf8_stream_decoder.sv
// Streaming UTF-8 decoder and validator. One byte of a string is taken per transfer on the
// in_ channel, with last marking the final byte; a byte is accepted each cycle that in_stall
// is low and fully handled in that cycle. A result is produced for each completed codepoint,
// for the first invalid or cut-off sequence, and always for the last byte (end_of_string
// set), after which the per-string state returns to its reset values. A two-entry output
// stage (result register plus skid register) lets input continue while a result waits;
// in_stall rises only when both entries are full. The user must write lax_mode through
// the cfg_ port only while idle, which the block does not enforce; it selects strict
// (1-4 byte forms up to 10FFFF, no surrogates) or lax (also 5-6 byte forms up to 7FFFFFFF).
module utf8_stream_decoder
  import u8sd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  u8sd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output u8sd_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_lax_mode
);

  logic             lax_r;
  logic [CP_W-1:0]  acc_r, acc_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] seq_len_r, seq_len_nxt;
  logic [POS_W-1:0] seq_start_r, seq_start_nxt;
  logic [POS_W-1:0] byte_pos_r, byte_pos_nxt;
  logic [POS_W-1:0] count_r, count_nxt;
  logic             err_seen_r, err_seen_nxt;

  logic      out_valid_r, skid_valid_r;
  u8sd_out_t out_data_r, skid_data_r;
  u8sd_out_t res;
  logic      emit;
  logic      in_fire;
  logic      out_free;

  logic [LEN_W-1:0] lead_n;
  logic [CP_W-1:0]  acc_shift;
  logic             complete, err;
  logic [CP_W-1:0]  cp;
  logic [LEN_W-1:0] blen;
  logic [7:0]       b;

  function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] v);
    logic [LEN_W-1:0] n;
    if (v < 8'h80) n = 3'd1;
    else if (v < 8'hC2) n = 3'd0;
    else if (v < 8'hE0) n = 3'd2;
    else if (v < 8'hF0) n = 3'd3;
    else if (v < 8'hF8) n = 3'd4;
    else if (v < 8'hFC) n = 3'd5;
    else if (v < 8'hFE) n = 3'd6;
    else n = 3'd0;
    return n;
  endfunction

  function automatic logic [CP_W-1:0] lead_bits(input logic [7:0] v, input logic [LEN_W-1:0] n);
    logic [CP_W-1:0] r;
    case (n)
      3'd2:    r = {26'd0, v[4:0]};
      3'd3:    r = {27'd0, v[3:0]};
      3'd4:    r = {28'd0, v[2:0]};
      3'd5:    r = {29'd0, v[1:0]};
      3'd6:    r = {30'd0, v[0]};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [CP_W-1:0] min_value(input logic [LEN_W-1:0] n);
    logic [CP_W-1:0] r;
    case (n)
      3'd2:    r = 31'h00000080;
      3'd3:    r = 31'h00000800;
      3'd4:    r = 31'h00010000;
      3'd5:    r = 31'h00200000;
      3'd6:    r = 31'h04000000;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    return (v >= SAT_CAP) ? SAT_CAP : v + 1'b1;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign b         = in_data.data_byte;
  assign lead_n    = lead_length(b);
  assign acc_shift = {acc_r[CP_W-7:0], b[5:0]};

  always_comb begin
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    seq_len_nxt   = seq_len_r;
    seq_start_nxt = seq_start_r;
    byte_pos_nxt  = byte_pos_r;
    count_nxt     = count_r;
    err_seen_nxt  = err_seen_r;
    complete      = 1'b0;
    err           = 1'b0;
    emit          = 1'b0;
    cp            = '0;
    blen          = '0;

    if (!err_seen_r) begin
      if (rem_r == '0) begin
        seq_start_nxt = byte_pos_r;
        if (lead_n == 3'd0 || (lead_n >= 3'd5 && !lax_r)) begin
          err = 1'b1;
        end else if (lead_n == 3'd1) begin
          complete = 1'b1;
          cp       = {23'd0, b};
          blen     = 3'd1;
        end else begin
          acc_nxt     = lead_bits(b, lead_n);
          seq_len_nxt = lead_n;
          rem_nxt     = lead_n - 3'd1;
        end
      end else if (b[7:6] != 2'b10) begin
        err = 1'b1;
      end else begin
        acc_nxt = acc_shift;
        rem_nxt = rem_r - 3'd1;
        if (rem_r == 3'd1) begin
          if (acc_shift < min_value(seq_len_r)) begin
            err = 1'b1;
          end else if (!lax_r && acc_shift >= SURR_LO && acc_shift <= SURR_HI) begin
            err = 1'b1;
          end else if (!lax_r && acc_shift > STRICT_MAX) begin
            err = 1'b1;
          end else begin
            complete = 1'b1;
            cp       = acc_shift;
            blen     = seq_len_r;
          end
        end
      end
      if (complete) begin
        count_nxt = sat_inc(count_r);
        emit      = 1'b1;
      end else if (!err && in_data.last) begin
        err = 1'b1;
      end
      if (err) begin
        err_seen_nxt = 1'b1;
        rem_nxt      = '0;
        emit         = 1'b1;
      end
    end
    if (in_data.last) begin
      emit = 1'b1;
    end

    res.codepoint       = cp;
    res.start_position  = seq_start_nxt;
    res.byte_length     = blen;
    res.codepoint_valid = complete;
    res.error           = err_seen_nxt;
    res.char_count      = count_nxt;
    res.end_of_string   = in_data.last;

    if (in_data.last) begin
      acc_nxt       = '0;
      rem_nxt       = '0;
      seq_len_nxt   = '0;
      seq_start_nxt = POS_W'(1);
      byte_pos_nxt  = POS_W'(1);
      count_nxt     = '0;
      err_seen_nxt  = 1'b0;
    end else begin
      byte_pos_nxt = sat_inc(byte_pos_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lax_r        <= 1'b0;
      acc_r        <= '0;
      rem_r        <= '0;
      seq_len_r    <= '0;
      seq_start_r  <= POS_W'(1);
      byte_pos_r   <= POS_W'(1);
      count_r      <= '0;
      err_seen_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        lax_r <= cfg_lax_mode;
      end
      if (in_fire) begin
        acc_r       <= acc_nxt;
        rem_r       <= rem_nxt;
        seq_len_r   <= seq_len_nxt;
        seq_start_r <= seq_start_nxt;
        byte_pos_r  <= byte_pos_nxt;
        count_r     <= count_nxt;
        err_seen_r  <= err_seen_nxt;
      end
      if (out_free) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_fire && emit;
        end
      end else if (in_fire && emit) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // result payloads
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_fire && emit) begin
        out_data_r <= res;
      end
    end else if (in_fire && emit) begin
      skid_data_r <= res;
    end
  end

endmodule

FILE: rtl/u8sd_checker.sv
module u8sd_checker
  import u8sd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input u8sd_out_t out_data
);

  // a waiting result holds until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_cp_xor_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.codepoint_valid && out_data.error))
    else $error("codepoint and error in one result");

  a_no_cp_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.codepoint_valid |->
      out_data.error && out_data.byte_length == '0 && out_data.codepoint == '0)
    else $error("result without codepoint is not an error result");

  a_cp_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.codepoint_valid |->
      out_data.byte_length != '0 && out_data.char_count != '0)
    else $error("codepoint result with zero length or count");

  a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.start_position != '0)
    else $error("start position zero");

endmodule

bind utf8_stream_decoder u8sd_checker u_u8sd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
